@@ hw/rtl/rmq_pkg.sv @@
// Shared constants and helpers for the rotation matrix to quaternion block.
// No dependencies; imported by every module of the block.
package rmq_pkg;

   localparam int DATA_W = 16;
   localparam int TOL_W = 29;
   localparam logic [TOL_W-1:0] TOL_RESET = 29'd26844;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

@@ hw/rtl/rmq_sqrt.sv @@
// Pipelined integer square root, one root bit per register stage.
// Depends on rmq_pkg.
module rmq_sqrt #(
   parameter int RAD_W = 32,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [RAD_W-1:0]  in_rad,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [RAD_W/2-1:0] out_root,
   output logic [SIDE_W-1:0] out_side
);
   import rmq_pkg::*;

   localparam int S_W = RAD_W / 2;
   localparam int RM_W = S_W + 3;

   logic              v_ff    [1:S_W];
   logic [S_W-1:0]    root_ff [1:S_W];
   logic [SIDE_W-1:0] side_ff [1:S_W];
   logic [RM_W-1:0]   rem_ff  [1:S_W-1];
   logic [RAD_W-1:0]  rad_ff  [1:S_W-1];

   for (genvar k = 0; k < S_W; k++) begin : g_stage
      logic              v_cur;
      logic [RM_W-1:0]   rem_cur, rem_sh, trial, rem_nxt;
      logic [S_W-1:0]    root_cur, root_nxt;
      logic [RAD_W-1:0]  rad_cur;
      logic [SIDE_W-1:0] side_cur;

      if (k == 0) begin : g_first
         assign v_cur = in_valid;
         assign rem_cur = '0;
         assign root_cur = '0;
         assign rad_cur = in_rad;
         assign side_cur = in_side;
      end else begin : g_rest
         assign v_cur = v_ff[k];
         assign rem_cur = rem_ff[k];
         assign root_cur = root_ff[k];
         assign rad_cur = rad_ff[k];
         assign side_cur = side_ff[k];
      end

      always_comb begin
         rem_sh = {rem_cur[RM_W-3:0], rad_cur[RAD_W-1 -: 2]};
         trial = {{(RM_W-S_W-2){1'b0}}, root_cur, 2'b01};
         if (rem_sh >= trial) begin
            rem_nxt = rem_sh - trial;
            root_nxt = {root_cur[S_W-2:0], 1'b1};
         end else begin
            rem_nxt = rem_sh;
            root_nxt = {root_cur[S_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_cur;
         end
         if (en) begin
            root_ff[k+1] <= root_nxt;
            side_ff[k+1] <= side_cur;
         end
      end

      if (k < S_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k+1] <= rem_nxt;
               rad_ff[k+1] <= rad_cur << 2;
            end
         end
      end
   end

   assign out_valid = v_ff[S_W];
   assign out_root = root_ff[S_W];
   assign out_side = side_ff[S_W];

endmodule

@@ hw/rtl/rmq_div.sv @@
// Pipelined restoring divider, four lanes over one shared divisor,
// one quotient bit per register stage. Depends on rmq_pkg.
module rmq_div #(
   parameter int Q_W = 15,
   parameter int N_W = 34,
   parameter int D_W = 16,
   parameter int SIDE_W = 9
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [3:0][N_W-1:0]      in_num,
   input  logic [D_W-1:0]           in_den,
   input  logic [SIDE_W-1:0]        in_side,
   output logic                     out_valid,
   output logic [3:0][Q_W-1:0]      out_quo,
   output logic [SIDE_W-1:0]        out_side
);
   import rmq_pkg::*;

   localparam int C_W = max_int(N_W, D_W + Q_W) + 1;

   logic                  v_ff    [1:Q_W];
   logic [3:0][Q_W-1:0]   quo_ff  [1:Q_W];
   logic [SIDE_W-1:0]     side_ff [1:Q_W];
   logic [3:0][C_W-1:0]   rem_ff  [1:Q_W-1];
   logic [D_W-1:0]        den_ff  [1:Q_W-1];

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      logic                v_cur;
      logic [3:0][C_W-1:0] rem_cur, rem_nxt;
      logic [3:0][Q_W-1:0] quo_cur, quo_nxt;
      logic [D_W-1:0]      den_cur;
      logic [SIDE_W-1:0]   side_cur;
      logic [C_W-1:0]      trial;

      if (k == 0) begin : g_first
         assign v_cur = in_valid;
         assign den_cur = in_den;
         assign side_cur = in_side;
         assign quo_cur = '0;
         for (genvar l = 0; l < 4; l++) begin : g_lane
            assign rem_cur[l] = C_W'(in_num[l]);
         end
      end else begin : g_rest
         assign v_cur = v_ff[k];
         assign den_cur = den_ff[k];
         assign side_cur = side_ff[k];
         assign quo_cur = quo_ff[k];
         assign rem_cur = rem_ff[k];
      end

      always_comb begin
         trial = C_W'(den_cur) << (Q_W - 1 - k);
         for (int l = 0; l < 4; l++) begin
            if (rem_cur[l] >= trial) begin
               rem_nxt[l] = rem_cur[l] - trial;
               quo_nxt[l] = {quo_cur[l][Q_W-2:0], 1'b1};
            end else begin
               rem_nxt[l] = rem_cur[l];
               quo_nxt[l] = {quo_cur[l][Q_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_cur;
         end
         if (en) begin
            quo_ff[k+1] <= quo_nxt;
            side_ff[k+1] <= side_cur;
         end
      end

      if (k < Q_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k+1] <= rem_nxt;
               den_ff[k+1] <= den_cur;
            end
         end
      end
   end

   assign out_valid = v_ff[Q_W];
   assign out_quo = quo_ff[Q_W];
   assign out_side = side_ff[Q_W];

endmodule

@@ hw/rtl/rotation_matrix_to_quaternion_top.sv @@
// Rotation matrix to quaternion, Shepperd four-branch method, fixed point.
// Register order: stage A, stage B, square root, stage C, divider, output queue; the square
// root and divider stages, one result bit each, set this depth.
// Throughput: one matrix per cycle until a two-entry output queue, holding results while rsp stalls, fills.
// Reset (synchronous, active high) empties the pipeline and loads the tolerance with 26844.
// Depends on rmq_pkg, rmq_sqrt and rmq_div.
module rotation_matrix_to_quaternion_top #(
   parameter int FRAC_BITS = 14
) (
   input  logic          clock,
   input  logic          reset,
   // req_tdata fields from bit 0 up: m00, m01, m02, m10, m11, m12, m20, m21, m22
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [143:0]  req_tdata,
   // rsp_tdata fields from bit 0 up: qw, qx, qy, qz
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [63:0]   rsp_tdata,
   // rsp_tuser fields: not_rotation
   output logic          rsp_tuser,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [rmq_pkg::TOL_W-1:0] csr_data
);
   import rmq_pkg::*;

   localparam int F = FRAC_BITS;
   localparam int D_W = max_int(34, 2 * F + 2) + 1;         // R*R^T entry
   localparam int T_W = max_int(F + 2, DATA_W) + 2;         // t and the four parts
   localparam int R_W = T_W - 1 + F;
   localparam int RAD_W = R_W + (R_W % 2);
   localparam int S_W = RAD_W / 2;
   localparam int N_W = max_int(T_W + F - 1, S_W) + 1;      // rounded numerator
   localparam int L_W = S_W + F + 1;
   localparam int CMP_W = max_int(N_W, L_W);
   localparam int Q_W = F + 1;
   localparam int V_W = max_int(F + 2, DATA_W);
   localparam int SQ_SIDE_W = 1 + 4 + 4 * T_W;
   localparam int DV_SIDE_W = 1 + 4 + 4;

   localparam logic signed [T_W-1:0] ONE_T = T_W'(1) << F;
   localparam logic signed [D_W-1:0] ONE2_D = D_W'(1) << (2 * F);

   typedef struct packed {
      logic        not_rotation;
      logic [63:0] data;
   } rsp_type;

   // Pairs (i, j) of R*R^T taken once: 00, 01, 02, 11, 12, 22
   localparam int PI [6] = '{0, 0, 0, 1, 1, 2};
   localparam int PJ [6] = '{0, 1, 2, 1, 2, 2};

   logic                     en;
   logic [TOL_W-1:0]         tol_ff;
   logic signed [DATA_W-1:0] m [3][3];

   // stage A: products, t and parts
   logic                     v_a_ff;
   logic signed [31:0]       prod_a_ff [6][3];
   logic signed [31:0]       prod_a_in [6][3];
   logic signed [T_W-1:0]    t_a_ff, t_a_in;
   logic signed [T_W-1:0]    part_a_ff [4];
   logic signed [T_W-1:0]    part_a_in [4];
   logic signed [DATA_W:0]   diag_sum;

   // stage B: orthogonality flag, magnitudes
   logic                     v_b_ff;
   logic                     bad_b_ff, bad_b_in;
   logic [T_W-2:0]           t_b_ff;
   logic [3:0]               neg_b_ff, neg_b_in;
   logic [3:0][T_W-1:0]      mag_b_ff, mag_b_in;
   logic signed [D_W-1:0]    dev [6];
   logic [D_W-1:0]           dev_abs [6];

   logic                     sq_valid;
   logic [S_W-1:0]           sq_root;
   logic [SQ_SIDE_W-1:0]     sq_side;
   logic [3:0][T_W-1:0]      sq_mag;

   // stage C: rounded numerators, saturation flags
   logic                     v_c_ff;
   logic [3:0][N_W-1:0]      num_c_ff, num_c_in;
   logic [S_W-1:0]           den_c_ff;
   logic [DV_SIDE_W-1:0]     side_c_ff;
   logic [3:0]               ovf_c_in;
   logic [L_W-1:0]           lim;

   logic                     dv_valid;
   logic [3:0][Q_W-1:0]      dv_quo;
   logic [DV_SIDE_W-1:0]     dv_side;
   logic                     dv_bad;
   logic [3:0]               dv_neg, dv_ovf;
   logic [V_W-1:0]           qv [4];
   logic [V_W-1:0]           qs [4];
   rsp_type                  res;

   // output queue
   rsp_type                  ent0_ff, ent1_ff;
   logic [1:0]               count_ff;
   logic                     push, pop;

   assign en = (count_ff != 2'd2);
   assign req_tready = en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_valid) begin
         tol_ff <= csr_data;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            m[i][j] = req_tdata[(i*3+j)*DATA_W +: DATA_W];
         end
      end
   end

   // Stage A: all products of R*R^T, branch pick and t
   always_comb begin
      for (int p = 0; p < 6; p++) begin
         for (int k = 0; k < 3; k++) begin
            prod_a_in[p][k] = m[PI[p]][k] * m[PJ[p]][k];
         end
      end
      diag_sum = (DATA_W+1)'(m[0][0]) + (DATA_W+1)'(m[1][1]);
      // part order: w, x, y, z
      if (m[2][2] < 0) begin
         if (m[0][0] > m[1][1]) begin
            t_a_in = ONE_T + T_W'(m[0][0]) - T_W'(m[1][1]) - T_W'(m[2][2]);
            part_a_in[1] = t_a_in;
            part_a_in[2] = T_W'(m[0][1]) + T_W'(m[1][0]);
            part_a_in[3] = T_W'(m[2][0]) + T_W'(m[0][2]);
            part_a_in[0] = T_W'(m[1][2]) - T_W'(m[2][1]);
         end else begin
            t_a_in = ONE_T - T_W'(m[0][0]) + T_W'(m[1][1]) - T_W'(m[2][2]);
            part_a_in[1] = T_W'(m[0][1]) + T_W'(m[1][0]);
            part_a_in[2] = t_a_in;
            part_a_in[3] = T_W'(m[1][2]) + T_W'(m[2][1]);
            part_a_in[0] = T_W'(m[2][0]) - T_W'(m[0][2]);
         end
      end else begin
         if (diag_sum < 0) begin
            t_a_in = ONE_T - T_W'(m[0][0]) - T_W'(m[1][1]) + T_W'(m[2][2]);
            part_a_in[1] = T_W'(m[2][0]) + T_W'(m[0][2]);
            part_a_in[2] = T_W'(m[1][2]) + T_W'(m[2][1]);
            part_a_in[3] = t_a_in;
            part_a_in[0] = T_W'(m[0][1]) - T_W'(m[1][0]);
         end else begin
            t_a_in = ONE_T + T_W'(m[0][0]) + T_W'(m[1][1]) + T_W'(m[2][2]);
            part_a_in[1] = T_W'(m[1][2]) - T_W'(m[2][1]);
            part_a_in[2] = T_W'(m[2][0]) - T_W'(m[0][2]);
            part_a_in[3] = T_W'(m[0][1]) - T_W'(m[1][0]);
            part_a_in[0] = t_a_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff <= 1'b0;
      end else if (en) begin
         v_a_ff <= req_tvalid;
      end
      if (en) begin
         prod_a_ff <= prod_a_in;
         t_a_ff <= t_a_in;
         part_a_ff <= part_a_in;
      end
   end

   // Stage B: deviation from identity against the tolerance, t <= 0 check, magnitudes
   always_comb begin
      bad_b_in = (t_a_ff <= 0);
      for (int p = 0; p < 6; p++) begin
         dev[p] = D_W'(prod_a_ff[p][0]) + D_W'(prod_a_ff[p][1]) + D_W'(prod_a_ff[p][2]);
         if (PI[p] == PJ[p]) begin
            dev[p] = dev[p] - ONE2_D;
         end
         dev_abs[p] = (dev[p] < 0) ? D_W'(-dev[p]) : D_W'(dev[p]);
         if (dev_abs[p] > D_W'(tol_ff)) begin
            bad_b_in = 1'b1;
         end
      end
      for (int l = 0; l < 4; l++) begin
         neg_b_in[l] = part_a_ff[l][T_W-1];
         mag_b_in[l] = neg_b_in[l] ? T_W'(-part_a_ff[l]) : T_W'(part_a_ff[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_b_ff <= 1'b0;
      end else if (en) begin
         v_b_ff <= v_a_ff;
      end
      if (en) begin
         bad_b_ff <= bad_b_in;
         t_b_ff <= t_a_ff[T_W-2:0];
         neg_b_ff <= neg_b_in;
         mag_b_ff <= mag_b_in;
      end
   end

   rmq_sqrt #(
      .RAD_W  (RAD_W),
      .SIDE_W (SQ_SIDE_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v_b_ff),
      .in_rad    (RAD_W'(t_b_ff) << F),
      .in_side   ({bad_b_ff, neg_b_ff, mag_b_ff}),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // Stage C: round half away from zero, flag quotients above one
   assign sq_mag = sq_side[4*T_W-1:0];
   assign lim = (L_W'(sq_root) << F) + L_W'(sq_root);

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         num_c_in[l] = (N_W'(sq_mag[l]) << (F - 1)) + N_W'(sq_root >> 1);
         ovf_c_in[l] = CMP_W'(num_c_in[l]) >= CMP_W'(lim);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_c_ff <= 1'b0;
      end else if (en) begin
         v_c_ff <= sq_valid;
      end
      if (en) begin
         num_c_ff <= num_c_in;
         den_c_ff <= sq_root;
         side_c_ff <= {sq_side[SQ_SIDE_W-1 -: 5], ovf_c_in};
      end
   end

   rmq_div #(
      .Q_W    (Q_W),
      .N_W    (N_W),
      .D_W    (S_W),
      .SIDE_W (DV_SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v_c_ff),
      .in_num    (num_c_ff),
      .in_den    (den_c_ff),
      .in_side   (side_c_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   // Saturate, restore the sign, zero everything on a failed check
   assign {dv_bad, dv_neg, dv_ovf} = dv_side;

   always_comb begin
      res.not_rotation = dv_bad;
      for (int l = 0; l < 4; l++) begin
         qv[l] = dv_ovf[l] ? (V_W'(1) << F) : V_W'(dv_quo[l]);
         qs[l] = dv_neg[l] ? (-qv[l]) : qv[l];
         res.data[l*DATA_W +: DATA_W] = dv_bad ? '0 : qs[l][DATA_W-1:0];
      end
   end

   // Two-entry output queue; the pipeline holds only when both entries are full
   assign push = dv_valid && en;
   assign pop = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         unique case ({push, pop})
            2'b10: count_ff <= count_ff + 2'd1;
            2'b01: count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
      unique case ({push, pop})
         2'b11: begin
            ent0_ff <= res;
         end
         2'b10: begin
            if (count_ff == 2'd0) begin
               ent0_ff <= res;
            end else begin
               ent1_ff <= res;
            end
         end
         2'b01: begin
            ent0_ff <= ent1_ff;
         end
         default: begin
            ent0_ff <= ent0_ff;
         end
      endcase
   end

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata = ent0_ff.data;
   assign rsp_tuser = ent0_ff.not_rotation;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("output queue count out of range");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 64'd0)
      else $error("failed check must give a zero quaternion");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 && !rsp_tready |=> count_ff == 2'd2 && $stable(ent0_ff))
      else $error("full queue changed while stalled");

endmodule

@@ dv/rotation_matrix_to_quaternion_top_tb.sv @@
// Self-checking testbench for rotation_matrix_to_quaternion_top: streams matrices,
// predicts each quaternion and error flag in SystemVerilog and compares every transfer.
// Depends on rmq_pkg and the block's RTL.
module rotation_matrix_to_quaternion_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rmq_pkg::*;

   localparam int FB = 14;
   localparam int ONE = 1 << FB;
   localparam int LATENCY = 40;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [15:0] qz, qy, qx, qw;
      logic        not_rot;
   } quat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [143:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [TOL_W-1:0] csr_data = '0;

   logic [TOL_W-1:0] tolerance;
   quat_type quat_fifo[$];
   int errors = 0;
   int matrices_sent = 0;
   int quats_seen = 0;
   int rejects_seen = 0;
   int idle_cycles = 0;
   bit rsp_stall_on = 1'b1;

   rotation_matrix_to_quaternion_top #(.FRAC_BITS(FB)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [15:0] scale_to_q14(longint p, longint unsigned s);
      longint unsigned mag, q;
      mag = (p < 0) ? longint'(-p) : longint'(p);
      q = ((mag << (FB - 1)) + (s >> 1)) / s;
      if (q > ONE) q = ONE;
      return (p < 0) ? 16'(-q) : 16'(q);
   endfunction

   // Orthogonality check, branch choice, then scale by 0.5/sqrt(t).
   function automatic quat_type predict_quat(logic [143:0] data);
      longint m[3][3];
      longint d, a, t, pw, px, py, pz;
      longint unsigned s;
      bit bad;
      quat_type q;
      bad = 1'b0;
      for (int i = 0; i < 9; i++) m[i / 3][i % 3] = longint'($signed(data[16*i +: 16]));
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            d = 0;
            for (int k = 0; k < 3; k++) d += m[i][k] * m[j][k];
            if (i == j) d -= longint'(1) << (2 * FB);
            a = (d < 0) ? -d : d;
            if (a > longint'(tolerance)) bad = 1'b1;
         end
      if (m[2][2] < 0) begin
         if (m[0][0] > m[1][1]) begin
            t = ONE + m[0][0] - m[1][1] - m[2][2];
            px = t; py = m[0][1] + m[1][0]; pz = m[2][0] + m[0][2]; pw = m[1][2] - m[2][1];
         end else begin
            t = ONE - m[0][0] + m[1][1] - m[2][2];
            px = m[0][1] + m[1][0]; py = t; pz = m[1][2] + m[2][1]; pw = m[2][0] - m[0][2];
         end
      end else begin
         if (m[0][0] < -m[1][1]) begin
            t = ONE - m[0][0] - m[1][1] + m[2][2];
            px = m[2][0] + m[0][2]; py = m[1][2] + m[2][1]; pz = t; pw = m[0][1] - m[1][0];
         end else begin
            t = ONE + m[0][0] + m[1][1] + m[2][2];
            px = m[1][2] - m[2][1]; py = m[2][0] - m[0][2]; pz = m[0][1] - m[1][0]; pw = t;
         end
      end
      if (t <= 0) bad = 1'b1;
      q = '0;
      if (bad) begin
         q.not_rot = 1'b1;
      end else begin
         s = int_sqrt(longint'(t) << FB);
         q.qw = scale_to_q14(pw, s);
         q.qx = scale_to_q14(px, s);
         q.qy = scale_to_q14(py, s);
         q.qz = scale_to_q14(pz, s);
      end
      return q;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s at %0t: got %h want %h", what, $realtime, got, want);
      errors++;
   endtask

   // Random gap: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Transfer one matrix and queue its predicted quaternion; drop valid only for a gap.
   task automatic send_matrix(logic [143:0] data);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= data;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      quat_fifo.push_back(predict_quat(data));
      matrices_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (quat_fifo.size() != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   task automatic write_tolerance(logic [TOL_W-1:0] value);
      drain_results();
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      tolerance = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [143:0] pack_matrix(int e[9]);
      logic [143:0] d;
      for (int i = 0; i < 9; i++) d[16*i +: 16] = 16'(e[i]);
      return d;
   endfunction

   // Build a rotation by composing rotations about random axes in real arithmetic,
   // then quantize to Q1.14.
   function automatic logic [143:0] random_rotation();
      real r[3][3], g[3][3], n[3][3];
      real ang;
      int ax, e[9];
      for (int i = 0; i < 3; i++) for (int j = 0; j < 3; j++) r[i][j] = (i == j);
      repeat (3) begin
         ang = ($urandom_range(0, 62831) / 10000.0);
         ax = $urandom_range(0, 2);
         for (int i = 0; i < 3; i++) for (int j = 0; j < 3; j++) g[i][j] = (i == j);
         g[(ax+1)%3][(ax+1)%3] = $cos(ang); g[(ax+2)%3][(ax+2)%3] = $cos(ang);
         g[(ax+1)%3][(ax+2)%3] = -$sin(ang); g[(ax+2)%3][(ax+1)%3] = $sin(ang);
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
               n[i][j] = 0.0;
               for (int k = 0; k < 3; k++) n[i][j] += r[i][k] * g[k][j];
            end
         r = n;
      end
      for (int i = 0; i < 9; i++) begin
         e[i] = $rtoi(r[i / 3][i % 3] * ONE + ((r[i / 3][i % 3] < 0) ? -0.5 : 0.5));
         // nudge by one LSB now and then to land near the tolerance edge
         if ($urandom_range(0, 7) == 0) e[i] += $urandom_range(0, 2) - 1;
      end
      return pack_matrix(e);
   endfunction

   function automatic logic [143:0] random_noise();
      logic [143:0] d;
      for (int i = 0; i < 9; i++)
         d[16*i +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                     : 16'($urandom_range(0, 2*ONE) - ONE);
      return d;
   endfunction

   // Sample each result transfer at the rising edge and compare with the oldest prediction.
   always @(posedge clock) begin
      quat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (quat_fifo.size() == 0) begin
            report_mismatch("unexpected result qw", rsp_tdata[15:0], 16'd0);
         end else begin
            want = quat_fifo.pop_front();
            quats_seen++;
            if (rsp_tuser) rejects_seen++;
            if (rsp_tdata[15:0] !== want.qw) report_mismatch("qw", rsp_tdata[15:0], want.qw);
            if (rsp_tdata[31:16] !== want.qx) report_mismatch("qx", rsp_tdata[31:16], want.qx);
            if (rsp_tdata[47:32] !== want.qy) report_mismatch("qy", rsp_tdata[47:32], want.qy);
            if (rsp_tdata[63:48] !== want.qz) report_mismatch("qz", rsp_tdata[63:48], want.qz);
            if (rsp_tuser !== want.not_rot)
               report_mismatch("not_rotation", 16'(rsp_tuser), 16'(want.not_rot));
         end
      end
   end

   // Stall the result side at random; stall_on turns into stretches of full speed.
   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) rsp_stall_on = !rsp_stall_on;
      rsp_tready <= rsp_stall_on ? (pick_gap() == 0) : 1'b1;
   end

   // Watchdog: end the run when no transfer happens for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("watchdog timeout, %0d results outstanding", quat_fifo.size());
         $display("FAILURE");
         $finish;
      end
   end

   // Directed: identity, the four branches, signs, extremes and non-orthogonal.
   task automatic test_directed();
      send_matrix(pack_matrix('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}));
      send_matrix(pack_matrix('{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}));
      send_matrix(pack_matrix('{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE}));
      send_matrix(pack_matrix('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE}));
      send_matrix(pack_matrix('{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE}));
      send_matrix(pack_matrix('{0, ONE, 0, -ONE, 0, 0, 0, 0, ONE}));
      send_matrix(pack_matrix('{ONE, 0, 0, 0, 0, -ONE, 0, ONE, 0}));
      send_matrix(pack_matrix('{0, 0, ONE, 0, ONE, 0, -ONE, 0, 0}));
      send_matrix(pack_matrix('{0, ONE, 0, 0, 0, ONE, ONE, 0, 0}));
      send_matrix(pack_matrix('{0, 0, ONE, ONE, 0, 0, 0, ONE, 0}));
      send_matrix(pack_matrix('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE - 1}));
      send_matrix(pack_matrix('{-32768, -32768, -32768, -32768, -32768, -32768,
                                -32768, -32768, -32768}));
      send_matrix(pack_matrix('{32767, 32767, 32767, 32767, 32767, 32767,
                                32767, 32767, 32767}));
      send_matrix(pack_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
   endtask

   // Loose tolerance lets non-rotations through: hits output saturation.
   task automatic test_loose_tolerance();
      write_tolerance(29'd268435456);
      send_matrix(pack_matrix('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}));
      send_matrix(pack_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
      send_matrix(pack_matrix('{ONE, ONE, ONE, ONE, 0, 0, 0, 0, -ONE}));
      send_matrix(pack_matrix('{0, ONE, -ONE, ONE, 0, ONE, -ONE, 0, 0}));
      repeat (100) send_matrix(random_noise());
      write_tolerance({TOL_W{1'b1}});
      repeat (100) send_matrix(random_noise());
   endtask

   task automatic test_random_rotations(int count, logic [TOL_W-1:0] tol);
      write_tolerance(tol);
      repeat (count) begin
         if ($urandom_range(0, 9) < 8) send_matrix(random_rotation());
         else send_matrix(random_noise());
      end
   endtask

   initial begin
      tolerance = TOL_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      // hold the sender until every pending quaternion has come back
      drain_results();
      test_loose_tolerance();
      test_random_rotations(50, 29'd0);
      test_random_rotations(500, TOL_RESET);
      test_random_rotations(400, 29'd65536);
      test_random_rotations(300, 29'd2000);
      test_random_rotations(200, 29'd4000000);
      drain_results();
      $display("covered %0d matrices, %0d results, %0d flagged as not a rotation",
               matrices_sent, quats_seen, rejects_seen);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", errors);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
